[src/wzad_pkg.sv]
// Shared constants and types for the window z-score anomaly detector.
// No dependencies; every other file of the block but wzad_ram imports this package.
package wzad_pkg;

  localparam int LIMB_W     = 32;
  localparam int MOP_W      = 2 * LIMB_W;
  localparam int Q_W        = 32;
  localparam int QB_W       = Q_W + 1;
  localparam int ROOT_W     = Q_W / 2;
  localparam int Z_W        = 16;
  localparam int THR_W      = 16;
  localparam int IDX_W      = 32;
  localparam int FRAC_SHIFT = 16;

  typedef logic [THR_W-1:0] thr_t;
  typedef logic [Z_W-1:0]   zscore_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam thr_t THR_RESET = 16'd768;

endpackage

[src/wzad_if.sv]
// Channel interfaces: sample input, score result and threshold write.
// Depends on wzad_pkg for the payload types.
interface wzad_sample_if #(parameter int SAMPLE_BITS = 24) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface wzad_result_if import wzad_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    window_ready;
  zscore_t zscore;
  logic    anomaly;
  idx_t    sample_index;

  modport source (output valid, output window_ready, output zscore, output anomaly,
                  output sample_index, input ready);
  modport sink (input valid, input window_ready, input zscore, input anomaly,
                input sample_index, output ready);
endinterface

interface wzad_cfg_if import wzad_pkg::*; ();
  logic valid;
  logic ready;
  thr_t anomaly_threshold;

  modport source (output valid, output anomaly_threshold, input ready);
  modport sink (input valid, input anomaly_threshold, output ready);
endinterface

[src/wzad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wzad_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wzad_mul.sv]
// Shared multiply unit: low ACC_W bits of a 64 x 64 product from four 32 x 32 partial products,
// one per cycle, registered and accumulated. Depends on wzad_pkg.
module wzad_mul import wzad_pkg::*; #(
  parameter int ACC_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MOP_W-1:0] a,
  input  logic [MOP_W-1:0] b,
  output logic             done,
  output logic [ACC_W-1:0] prod
);

  logic [MOP_W-1:0]   a_r;
  logic [MOP_W-1:0]   b_r;
  logic [1:0]         step_r;
  logic [1:0]         sh_r;
  logic               busy_r;
  logic               pp_v_r;
  logic               done_r;
  logic [MOP_W-1:0]   pp_r;
  logic [ACC_W-1:0]   acc_r;
  logic [LIMB_W-1:0]  a_limb;
  logic [LIMB_W-1:0]  b_limb;
  logic [2*MOP_W-1:0] pp_ext;
  logic [2*MOP_W-1:0] pp_sh;

  always_comb begin
    a_limb = step_r[0] ? a_r[MOP_W-1:LIMB_W] : a_r[LIMB_W-1:0];
    b_limb = step_r[1] ? b_r[MOP_W-1:LIMB_W] : b_r[LIMB_W-1:0];
    pp_ext = {{MOP_W{1'b0}}, pp_r};
    case (sh_r)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << LIMB_W;
      2'd2:    pp_sh = pp_ext << (2 * LIMB_W);
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= pp_v_r && !busy_r && !start;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
        pp_v_r <= 1'b0;
      end else begin
        if (busy_r) begin
          pp_r   <= a_limb * b_limb;
          sh_r   <= {1'b0, step_r[0]} + {1'b0, step_r[1]};
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            busy_r <= 1'b0;
          end
        end
        pp_v_r <= busy_r;
        if (pp_v_r) begin
          acc_r <= acc_r + pp_sh[ACC_W-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[src/wzad_div.sv]
// Restoring divider, one quotient bit per cycle; quotient saturates at 32 bits.
// Depends on wzad_pkg.
module wzad_div import wzad_pkg::*; #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int DIV_W = DEN_W + QB_W;
  localparam int CNT_W = $clog2(QB_W + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [QB_W-1:0]  quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic             ge;

  assign ge = rem_r >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1)) && !start;
      if (start) begin
        rem_r <= DIV_W'(num);
        dvs_r <= DIV_W'({den, {Q_W{1'b0}}});
        quo_r <= '0;
        cnt_r <= CNT_W'(QB_W);
      end else if (cnt_r != '0) begin
        if (ge) begin
          rem_r <= rem_r - dvs_r;
        end
        quo_r <= {quo_r[QB_W-2:0], ge};
        dvs_r <= dvs_r >> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r[QB_W-1] ? {Q_W{1'b1}} : quo_r[Q_W-1:0];

endmodule

[src/wzad_sqrt.sv]
// Digit-by-digit integer square root of a 32-bit word, one root bit per cycle.
// Depends on wzad_pkg.
module wzad_sqrt import wzad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [Q_W-1:0]    op,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [Q_W-1:0]   op_r;
  logic [Q_W-1:0]   res_r;
  logic [Q_W-1:0]   one_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [Q_W:0]     trial;
  logic             fits;

  assign trial = {1'b0, res_r} + {1'b0, one_r};
  assign fits  = {1'b0, op_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1)) && !start;
      if (start) begin
        op_r  <= op;
        res_r <= '0;
        one_r <= {2'b01, {(Q_W-2){1'b0}}};
        cnt_r <= CNT_W'(ROOT_W);
      end else if (cnt_r != '0) begin
        if (fits) begin
          op_r  <= op_r - trial[Q_W-1:0];
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

[src/window_zscore_anomaly_detector_core.sv]
// Window z-score anomaly detector: top level, sequencer and window state.
// One word at a time: once the window is full each word takes four multiplies, a divide
// and a root (divide and root skipped when the variance is zero); in warm-up, two multiplies.
// Next word taken the cycle after the result is registered, which waits while the output stalls.
// rst_n (synchronous) empties the window, zeroes sums and counter, threshold to 3.0.
// Depends on wzad_pkg, wzad_if, wzad_ram, wzad_mul, wzad_div and wzad_sqrt.
module window_zscore_anomaly_detector_core import wzad_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  wzad_sample_if.sink   in_ch,
  wzad_result_if.source out_ch,
  wzad_cfg_if.sink      cfg_ch
);

  localparam int CW     = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + CW;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CW;
  localparam int XX_W   = 2 * SAMPLE_BITS;
  localparam int ACC_W  = 2 * SUM_W;
  localparam int V_W    = SQ_W + CW;
  localparam int DEN_W  = V_W + CW;
  localparam int T_W    = ACC_W + CW + FRAC_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MXX, S_MOO, S_MSS, S_MDD, S_VAR, S_TGT, S_DST, S_DIV, S_SQRT, S_UPD
  } state_t;

  state_t               state_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [SAMPLE_BITS-1:0] old_r;
  logic [SUM_W-1:0]     dev_r;
  logic [XX_W-1:0]      xx_r;
  logic [XX_W-1:0]      oo_r;
  logic [ACC_W-1:0]     ss_r;
  logic [ACC_W-1:0]     dd_r;
  logic [V_W-1:0]       v_r;
  logic [DEN_W-1:0]     den_r;
  logic [T_W-1:0]       t_r;
  zscore_t              z_r;
  logic                 scored_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SQ_W-1:0]      sq_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [CW-1:0]        fill_r;
  idx_t                 cnt_r;
  thr_t                 thr_r;
  logic                 out_valid_r;
  logic                 out_wr_r;
  zscore_t              out_z_r;
  logic                 out_anom_r;
  idx_t                 out_idx_r;

  logic [SUM_W-1:0]       nx;
  logic [SUM_W-1:0]       dev_nxt;
  logic                   out_free;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   mul_start;
  logic [MOP_W-1:0]       mul_a;
  logic [MOP_W-1:0]       mul_b;
  logic                   mul_done;
  logic [ACC_W-1:0]       mul_prod;
  logic                   div_done;
  logic [Q_W-1:0]         div_q;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [ROOT_W-1:0]      sqrt_root;

  assign nx       = SUM_W'(WINDOW) * SUM_W'(x_r);
  assign dev_nxt  = (nx >= sum_r) ? (nx - sum_r) : (sum_r - nx);
  assign out_free = !out_valid_r || out_ch.ready;
  assign ram_we   = (state_r == S_UPD) && out_free;

  always_comb begin
    case (state_r)
      S_RD: begin
        mul_a = MOP_W'(x_r);
        mul_b = MOP_W'(x_r);
      end
      S_MXX: begin
        mul_a = MOP_W'(old_r);
        mul_b = MOP_W'(old_r);
      end
      S_MOO: begin
        mul_a = MOP_W'(sum_r);
        mul_b = MOP_W'(sum_r);
      end
      S_MSS: begin
        mul_a = MOP_W'(dev_r);
        mul_b = MOP_W'(dev_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start  = (state_r == S_RD) ||
                      (mul_done && ((state_r == S_MXX) || (state_r == S_MSS) ||
                                    ((state_r == S_MOO) && scored_r)));
  assign sqrt_start = (state_r == S_DIV) && div_done;

  wzad_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (x_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  wzad_mul #(
    .ACC_W (ACC_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wzad_div #(
    .NUM_W (T_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DST),
    .num   (t_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  wzad_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .op    (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      sq_r        <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
      scored_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.anomaly_threshold;
      end
      if (out_valid_r && out_ch.ready && (state_r != S_UPD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r      <= in_ch.sample_value;
            scored_r <= (fill_r == CW'(WINDOW));
            z_r      <= '0;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          old_r   <= scored_r ? ram_rdata : '0;
          dev_r   <= dev_nxt;
          state_r <= S_MXX;
        end
        S_MXX: begin
          if (mul_done) begin
            xx_r    <= mul_prod[XX_W-1:0];
            state_r <= S_MOO;
          end
        end
        S_MOO: begin
          if (mul_done) begin
            oo_r    <= mul_prod[XX_W-1:0];
            state_r <= scored_r ? S_MSS : S_UPD;
          end
        end
        S_MSS: begin
          if (mul_done) begin
            ss_r    <= mul_prod;
            state_r <= S_MDD;
          end
        end
        S_MDD: begin
          if (mul_done) begin
            dd_r    <= mul_prod;
            state_r <= S_VAR;
          end
        end
        S_VAR: begin
          v_r     <= V_W'(WINDOW) * V_W'(sq_r) - V_W'(ss_r);
          state_r <= S_TGT;
        end
        S_TGT: begin
          den_r   <= DEN_W'(WINDOW) * DEN_W'(v_r);
          t_r     <= (T_W'(WINDOW - 1) * T_W'(dd_r)) << FRAC_SHIFT;
          state_r <= (v_r == '0) ? S_UPD : S_DST;
        end
        S_DST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            z_r     <= sqrt_root;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_wr_r    <= scored_r;
            out_z_r     <= z_r;
            out_anom_r  <= scored_r && (z_r > thr_r);
            out_idx_r   <= cnt_r;
            sum_r       <= sum_r - SUM_W'(old_r) + SUM_W'(x_r);
            sq_r        <= sq_r - SQ_W'(oo_r) + SQ_W'(xx_r);
            slot_r      <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
            if (fill_r != CW'(WINDOW)) begin
              fill_r <= fill_r + CW'(1);
            end
            if (cnt_r != {IDX_W{1'b1}}) begin
              cnt_r <= cnt_r + IDX_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_ready = out_wr_r;
  assign out_ch.zscore       = out_z_r;
  assign out_ch.anomaly      = out_anom_r;
  assign out_ch.sample_index = out_idx_r;

endmodule

[test/wzad_score_checker.sv]
// Score checker for the window z-score anomaly detector: watches the three channels,
// keeps its own window, sums and threshold, and compares every score word in order.
// Depends on wzad_pkg for the payload types and widths.
module wzad_score_checker import wzad_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_window_ready,
  input  zscore_t                out_zscore,
  input  logic                   out_anomaly,
  input  idx_t                   out_sample_index,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  thr_t                   cfg_threshold,
  output int                     fail_count,
  output int                     backlog,
  output int                     checked,
  output int                     flagged
);

  typedef struct packed {
    logic    window_ready;
    zscore_t zscore;
    logic    anomaly;
    idx_t    sample_index;
  } score_word_t;

  score_word_t            pending_scores[$];
  logic [SAMPLE_BITS-1:0] held_samples[WINDOW];
  int                     oldest_slot;
  int                     held_count;
  logic [127:0]           held_sum;
  logic [127:0]           held_square_sum;
  idx_t                   stream_pos;
  thr_t                   threshold;

  // largest r with r*r * n * (n*Q - S*S) <= 2^16 * (n-1) * |n*x - S|^2
  function automatic zscore_t zscore_of(input logic [SAMPLE_BITS-1:0] x);
    logic [127:0] scaled;
    logic [127:0] dev;
    logic [127:0] var_n;
    logic [127:0] den;
    logic [127:0] goal;
    logic [127:0] cand;
    zscore_t      r;
    r      = '0;
    scaled = 128'(x) * 128'(WINDOW);
    dev    = (scaled >= held_sum) ? scaled - held_sum : held_sum - scaled;
    var_n  = held_square_sum * 128'(WINDOW) - held_sum * held_sum;
    if (var_n == 0) return '0;
    den  = var_n * 128'(WINDOW);
    goal = dev * dev * (128'(WINDOW - 1) << FRAC_SHIFT);
    for (int b = Z_W - 1; b >= 0; b--) begin
      cand = 128'(r) | (128'd1 << b);
      if (den * cand * cand <= goal) r = cand[Z_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v, input idx_t at);
    if (want_v !== got_v) begin
      $display("%0t: %s of sample %0d expected %0d, got %0d", $time, field, at, want_v,
               got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    score_word_t  want;
    int           slot;
    logic [127:0] leaving_sq;
    if (!rst_n) begin
      foreach (held_samples[i]) held_samples[i] = '0;
      oldest_slot     = 0;
      held_count      = 0;
      held_sum        = '0;
      held_square_sum = '0;
      stream_pos      = '0;
      threshold       = THR_RESET;
      pending_scores.delete();
      fail_count      = 0;
      checked         = 0;
      flagged         = 0;
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (out_anomaly === 1'b1) flagged++;
        if (pending_scores.size() == 0) begin
          $display("%0t: score word for index %0d with no sample pending", $time,
                   out_sample_index);
          fail_count++;
        end else begin
          want = pending_scores.pop_front();
          check_field("window_ready", want.window_ready, out_window_ready, want.sample_index);
          check_field("zscore", want.zscore, out_zscore, want.sample_index);
          check_field("anomaly", want.anomaly, out_anomaly, want.sample_index);
          check_field("sample_index", want.sample_index, out_sample_index, want.sample_index);
        end
      end
      if (in_valid && in_ready) begin
        want.window_ready = (held_count >= WINDOW);
        want.zscore       = want.window_ready ? zscore_of(in_sample) : '0;
        want.anomaly      = want.window_ready && (want.zscore > threshold);
        want.sample_index = stream_pos;
        pending_scores    = {pending_scores, want};
        if (stream_pos != '1) stream_pos++;
        if (want.window_ready) begin
          slot            = oldest_slot;
          leaving_sq      = 128'(held_samples[slot]) * 128'(held_samples[slot]);
          held_sum        = held_sum - 128'(held_samples[slot]);
          held_square_sum = held_square_sum - leaving_sq;
          held_samples[slot] = in_sample;
          oldest_slot     = (slot + 1) % WINDOW;
        end else begin
          held_samples[held_count] = in_sample;
          held_count++;
          oldest_slot = held_count % WINDOW;
        end
        held_sum        = held_sum + 128'(in_sample);
        held_square_sum = held_square_sum + 128'(in_sample) * 128'(in_sample);
      end
      if (cfg_valid && cfg_ready) threshold = cfg_threshold;
    end
    backlog = pending_scores.size();
  end

endmodule

[test/testbench.sv]
// Top of the detector testbench: clock, reset, sample and threshold stimulus, verdict.
// Instantiates window_zscore_anomaly_detector_core beside wzad_score_checker;
// depends on wzad_pkg and the channel interfaces in wzad_if.
module testbench;
  import wzad_pkg::*;

  localparam int WINDOW        = 10;
  localparam int SAMPLE_BITS   = 24;
  localparam int ITEM_GOAL     = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 120;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef enum int {SHAPE_NEAR, SHAPE_SPIKE, SHAPE_WIDE, SHAPE_FLAT} shape_t;

  localparam sample_t SAMPLE_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;

  wzad_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  wzad_result_if out_ch ();
  wzad_cfg_if    cfg_ch ();

  int score_fails;
  int backlog;
  int checked;
  int flagged;

  int          sent;
  int          phases;
  int          burst_left;
  int          idle_cycles;
  sample_t     base;
  int          spread;
  logic [15:0] stall_pattern;
  int          pattern_pos;

  sample_t warm_up[WINDOW] = '{24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h000001,
                               24'hFFFFFE, 24'h800000, 24'h7FFFFF, 24'h00FF00, 24'h000000};

  window_zscore_anomaly_detector_core #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  wzad_score_checker #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) score_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_sample(in_ch.sample_value),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_window_ready(out_ch.window_ready),
    .out_zscore(out_ch.zscore),
    .out_anomaly(out_ch.anomaly),
    .out_sample_index(out_ch.sample_index),
    .cfg_valid(cfg_ch.valid),
    .cfg_ready(cfg_ch.ready),
    .cfg_threshold(cfg_ch.anomaly_threshold),
    .fail_count(score_fails),
    .backlog(backlog),
    .checked(checked),
    .flagged(flagged)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (pattern_pos == 0) stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    out_ch.ready <= stall_pattern[pattern_pos];
    pattern_pos = (pattern_pos + 1) % 16;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic sample_t make_sample();
    int          pick;
    shape_t      shape;
    logic [31:0] wide;
    logic [31:0] amount;
    pick  = $urandom_range(0, 99);
    shape = (pick < 70) ? SHAPE_NEAR : (pick < 80) ? SHAPE_SPIKE :
            (pick < 90) ? SHAPE_WIDE : SHAPE_FLAT;
    case (shape)
      SHAPE_NEAR: wide = base + $urandom_range(0, spread);
      SHAPE_SPIKE: begin
        amount = (spread + 1) * $urandom_range(4, 16) + $urandom_range(1, 64);
        if ($urandom_range(0, 1) == 1 && base >= amount) wide = base - amount;
        else wide = base + amount;
      end
      SHAPE_WIDE: wide = $urandom_range(0, SAMPLE_MAX);
      default: wide = base;
    endcase
    return (wide > SAMPLE_MAX) ? SAMPLE_MAX : wide[SAMPLE_BITS-1:0];
  endfunction

  task automatic push_sample(input sample_t x);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= x;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input thr_t t);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.anomaly_threshold <= t;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    sample_t x;
    thr_t    t;
    zscore_t z;
    in_ch.valid              = 1'b0;
    in_ch.sample_value       = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.anomaly_threshold = '0;
    out_ch.ready             = 1'b0;
    rst_n                    = 1'b0;
    sent                     = 0;
    phases                   = 0;
    burst_left               = 0;
    idle_cycles              = 0;
    pattern_pos              = 0;
    base                     = '0;
    spread                   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (warm_up[i]) push_sample(warm_up[i]);
    push_sample(24'h800000);
    repeat (WINDOW) push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX - 1);
    push_sample('0);

    settle();
    z = score_check.zscore_of(24'h400000);
    write_threshold(z);
    push_sample(24'h400000);
    settle();
    z = score_check.zscore_of(24'h123456);
    write_threshold((z == 0) ? z : z - zscore_t'(1));
    push_sample(24'h123456);

    while (sent < ITEM_GOAL) begin
      settle();
      phases++;
      base   = $urandom_range(0, SAMPLE_MAX);
      spread = (1 << $urandom_range(0, 12)) - 1;
      x      = make_sample();
      case ($urandom_range(0, 4))
        0: t = '0;
        1: t = '1;
        2: t = thr_t'($urandom);
        3: t = thr_t'($urandom_range(128, 1024));
        default: begin
          z = score_check.zscore_of(x);
          t = (z == 0) ? z : z - thr_t'($urandom_range(0, 1));
        end
      endcase
      write_threshold(t);
      push_sample(x);
      repeat ($urandom_range(20, 80)) push_sample(make_sample());
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples across %0d threshold phases after warm-up and edge cases;",
             sent, phases);
    $display("checked %0d score words, %0d of them flagged.", checked, flagged);
    if (score_fails == 0 && backlog == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[window_zscore_anomaly_detector_core.f]
src/wzad_pkg.sv
src/wzad_if.sv
src/wzad_ram.sv
src/wzad_mul.sv
src/wzad_div.sv
src/wzad_sqrt.sv
src/window_zscore_anomaly_detector_core.sv
test/wzad_score_checker.sv
test/testbench.sv
